[src/hds_pkg.sv]
package hds_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WCNT_W     = COL_W + 1;
  localparam int SAMPLE_W   = 32;
  localparam int ROWS_W     = 16;
  localparam int ROW_W      = 17;
  localparam int GAIN_W     = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = 52;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN     = 2'd2;

  localparam int RST_ROW_WIDTH = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam logic [ROWS_W-1:0] RST_INTERIOR_ROWS = 16'd1024;
  localparam logic [GAIN_W-1:0] RST_DIFF_GAIN     = 17'd32768;
  localparam logic [GAIN_W-1:0] GAIN_ONE          = 17'd65536;

  typedef logic [COL_W-1:0] col_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Line store access issued with every accepted word.
  typedef struct packed {
    logic en;
    col_t waddr;
    col_t raddr;
  } ls_req_t;

  // Stencil window for the column being processed.
  typedef struct packed {
    sample_t ctr;
    sample_t up;
    sample_t right;
  } win_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    sample_t                 ctr;
    logic                    last;
  } stage_t;

endpackage

[src/hds_line_store.sv]
module hds_line_store (
  input  logic                clk,
  input  logic                rst_n,
  input  hds_pkg::ls_req_t    req,
  input  hds_pkg::sample_t    wr_new,
  input  hds_pkg::sample_t    wr_old,
  output hds_pkg::win_t       win
);

  hds_pkg::sample_t newer_mem [hds_pkg::MAX_WIDTH];
  hds_pkg::sample_t older_mem [hds_pkg::MAX_WIDTH];

  hds_pkg::sample_t rd_c_r;
  hds_pkg::sample_t rd_r_r;
  hds_pkg::sample_t rd_u_r;
  hds_pkg::sample_t byp_new_r;
  hds_pkg::sample_t byp_old_r;
  logic             hit_c_r;
  logic             hit_r_r;
  hds_pkg::col_t    raddr1;

  assign raddr1 = req.raddr + 1'b1;

  // Reads return the contents before this cycle's write; a read of the
  // column being written takes the written word from the bypass registers.
  always_ff @(posedge clk) begin
    if (req.en) begin
      newer_mem[req.waddr] <= wr_new;
      older_mem[req.waddr] <= wr_old;
      rd_c_r    <= newer_mem[req.raddr];
      rd_r_r    <= newer_mem[raddr1];
      rd_u_r    <= older_mem[req.raddr];
      byp_new_r <= wr_new;
      byp_old_r <= wr_old;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_c_r <= 1'b0;
      hit_r_r <= 1'b0;
    end else if (req.en) begin
      hit_c_r <= (req.raddr == req.waddr);
      hit_r_r <= (raddr1 == req.waddr);
    end
  end

  assign win.ctr   = hit_c_r ? byp_new_r : rd_c_r;
  assign win.up    = hit_c_r ? byp_old_r : rd_u_r;
  assign win.right = hit_r_r ? byp_new_r : rd_r_r;

endmodule

[src/hds_pipe_cell.sv]
module hds_pipe_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  hds_pkg::stage_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hds_pkg::stage_t   dn_data
);

  logic            valid_r;
  hds_pkg::stage_t data_r;

  // The cell takes a new word whenever it is empty or its word moves on.
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= up_data;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[src/heat_diffusion_stencil.sv]
// A result is registered through the four pipeline cells in turn, starting at
// the edge that accepts the sample below its cell; an output stall holds it.
// Throughput: one word per cycle unless out_tready stalls; the line store does
// one write and its next-column reads in the same cycle; four pipeline cells follow.
// Reset: position returns to row 0, column 0, registers take their reset
// values and the pipeline empties; line stores are not cleared.
module heat_diffusion_stencil (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,   // [31:0] sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata,  // [31:0] new_value
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [hds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [hds_pkg::WCNT_W-1:0] w_eff_r;
  logic [hds_pkg::ROWS_W-1:0] rows_eff_r;
  logic [hds_pkg::GAIN_W-1:0] gain_eff_r;
  hds_pkg::col_t              col_r;
  hds_pkg::col_t              col_nxt;
  logic [hds_pkg::ROW_W-1:0]  row_r;
  logic [hds_pkg::ROW_W-1:0]  row_nxt;
  hds_pkg::sample_t           left_r;

  logic                       in_fire;
  logic                       cfg_hit;
  logic                       last_col;
  logic                       last_row;
  logic [31:0]                rw32;
  logic [hds_pkg::WCNT_W-1:0] w_new;
  hds_pkg::sample_t           sample;
  hds_pkg::sample_t           left_m;
  hds_pkg::sample_t           right_m;
  logic signed [33:0]         sum0;

  hds_pkg::ls_req_t           ls_req;
  hds_pkg::win_t              win;

  logic                       v0, v1, v2, v3;
  logic                       r0, r1, r2, r3;
  logic                       in_valid0;
  hds_pkg::stage_t            d_in0, d_out0, d_in1, d_out1, d_in2, d_out2, d_in3, d_out3;

  logic signed [33:0]         diff;
  logic signed [17:0]         gain_s;
  logic signed [51:0]         prod;
  logic signed [35:0]         nv;
  hds_pkg::sample_t           nv_sat;

  assign in_fire = in_tvalid && in_tready;
  assign cfg_hit = cfg_we && (cfg_index == hds_pkg::CFG_ROW_WIDTH ||
                              cfg_index == hds_pkg::CFG_INTERIOR_ROWS ||
                              cfg_index == hds_pkg::CFG_DIFF_GAIN);

  // Configuration, stored already clamped to the working range.
  assign rw32 = 32'(cfg_data[10:0]);
  always_comb begin
    if (rw32 == 32'd0) begin
      w_new = hds_pkg::WCNT_W'(1);
    end else if (rw32 > 32'(hds_pkg::MAX_WIDTH)) begin
      w_new = hds_pkg::WCNT_W'(hds_pkg::MAX_WIDTH);
    end else begin
      w_new = hds_pkg::WCNT_W'(rw32);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r    <= hds_pkg::WCNT_W'(hds_pkg::RST_ROW_WIDTH);
      rows_eff_r <= hds_pkg::RST_INTERIOR_ROWS;
      gain_eff_r <= hds_pkg::RST_DIFF_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        hds_pkg::CFG_ROW_WIDTH: begin
          w_eff_r <= w_new;
        end
        hds_pkg::CFG_INTERIOR_ROWS: begin
          rows_eff_r <= (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
        end
        hds_pkg::CFG_DIFF_GAIN: begin
          gain_eff_r <= (cfg_data > hds_pkg::GAIN_ONE) ? hds_pkg::GAIN_ONE : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Scan position.
  assign last_col = (({1'b0, col_r} + hds_pkg::WCNT_W'(1)) == w_eff_r);
  assign last_row = (row_r == ({1'b0, rows_eff_r} + hds_pkg::ROW_W'(1)));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_fire) begin
        left_r <= win.ctr;
      end
    end
  end

  // Line stores: fetch the window of the column that comes next.
  assign ls_req.en    = in_fire;
  assign ls_req.waddr = col_r;
  assign ls_req.raddr = last_col ? '0 : col_r + 1'b1;

  hds_line_store u_line_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ls_req),
    .wr_new (sample),
    .wr_old (win.ctr),
    .win    (win)
  );

  // Stage 0: neighbor sum. The borders left and right are zero.
  assign sample  = $signed(in_tdata);
  assign left_m  = (col_r == '0) ? '0 : left_r;
  assign right_m = last_col ? '0 : win.right;
  assign sum0    = 34'(win.up) + 34'(sample) + 34'(left_m) + 34'(right_m);

  assign in_valid0  = in_fire && (row_r >= hds_pkg::ROW_W'(2));
  assign d_in0.acc  = hds_pkg::ACC_W'(sum0);
  assign d_in0.ctr  = win.ctr;
  assign d_in0.last = last_row && last_col;
  assign in_tready  = r0;

  hds_pipe_cell u_cell0 (
    .clk(clk), .rst_n(rst_n),
    .up_valid(in_tvalid && (row_r >= hds_pkg::ROW_W'(2))), .up_ready(r0), .up_data(d_in0),
    .dn_valid(v0), .dn_ready(r1), .dn_data(d_out0)
  );

  // Stage 1: floored quarter of the sum, minus the center.
  assign diff       = ($signed(d_out0.acc[33:0]) >>> 2) - 34'(d_out0.ctr);
  assign d_in1.acc  = hds_pkg::ACC_W'(diff);
  assign d_in1.ctr  = d_out0.ctr;
  assign d_in1.last = d_out0.last;

  hds_pipe_cell u_cell1 (
    .clk(clk), .rst_n(rst_n),
    .up_valid(v0), .up_ready(r1), .up_data(d_in1),
    .dn_valid(v1), .dn_ready(r2), .dn_data(d_out1)
  );

  // Stage 2: scale by the gain.
  assign gain_s     = $signed({1'b0, gain_eff_r});
  assign prod       = $signed(d_out1.acc[33:0]) * gain_s;
  assign d_in2.acc  = prod;
  assign d_in2.ctr  = d_out1.ctr;
  assign d_in2.last = d_out1.last;

  hds_pipe_cell u_cell2 (
    .clk(clk), .rst_n(rst_n),
    .up_valid(v1), .up_ready(r2), .up_data(d_in2),
    .dn_valid(v2), .dn_ready(r3), .dn_data(d_out2)
  );

  // Stage 3: floored Q1.16 scaling, add back the center and saturate.
  assign nv = 36'(d_out2.ctr) + 36'(d_out2.acc >>> 16);
  always_comb begin
    if (nv > 36'sd2147483647) begin
      nv_sat = 32'sh7FFFFFFF;
    end else if (nv < -36'sd2147483648) begin
      nv_sat = 32'sh80000000;
    end else begin
      nv_sat = nv[31:0];
    end
  end
  assign d_in3.acc  = hds_pkg::ACC_W'(nv_sat);
  assign d_in3.ctr  = d_out2.ctr;
  assign d_in3.last = d_out2.last;

  hds_pipe_cell u_cell3 (
    .clk(clk), .rst_n(rst_n),
    .up_valid(v2), .up_ready(r3), .up_data(d_in3),
    .dn_valid(v3), .dn_ready(out_tready), .dn_data(d_out3)
  );

  assign out_tvalid = v3;
  assign out_tdata  = d_out3.acc[31:0];
  assign out_tlast  = d_out3.last;

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_r == '0 && row_r == '0))
    else $error("register write did not restart the frame");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < w_eff_r))
    else $error("column position beyond row width");

  a_halo_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_valid0) |=> !v0)
    else $error("halo row word produced a result");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_hit && last_col && last_row) |=> (col_r == '0 && row_r == '0))
    else $error("frame did not wrap after the bottom halo row");

endmodule
